// ===== src/psr_pkg.sv =====
// Shared constants, types and helpers of the particle resampler.
`timescale 1ns / 1ps

package psr_pkg;

  // Sizing of the particle set and of the stored values
  localparam int MAX_PARTICLES = 64;
  localparam int COORD_BITS    = 16;
  localparam int WEIGHT_BITS   = 16;

  // Fixed field widths of the stream items
  localparam int FIELD_BITS = 16;
  localparam int SLOT_BITS  = 6;
  localparam int CFG_BITS   = 7;
  localparam int FRAC_BITS  = 16;

  // Derived widths
  localparam int IDX_BITS      = $clog2(MAX_PARTICLES);
  localparam int CNT_BITS      = $clog2(MAX_PARTICLES + 1);
  localparam int SUM_BITS      = WEIGHT_BITS + IDX_BITS;
  localparam int LHS_BITS      = SUM_BITS + CNT_BITS;
  localparam int CMP_BITS      = LHS_BITS + FRAC_BITS;
  localparam int TGT_BITS      = IDX_BITS + FRAC_BITS + SUM_BITS;
  localparam int WPROD_BITS    = WEIGHT_BITS + CNT_BITS;
  localparam int DIV_STEP_BITS = $clog2(WEIGHT_BITS + 1);

  localparam logic [SLOT_BITS:0] SLOT_LIMIT = (SLOT_BITS + 1)'(MAX_PARTICLES);
  localparam logic [CFG_BITS-1:0] CFG_MAX   = CFG_BITS'(MAX_PARTICLES);
  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(64);

  // Operation codes carried in tuser
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_RESAMPLE = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [FIELD_BITS-1:0] heading;
  } pose_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]         slot;
    logic signed [FIELD_BITS-1:0] pos_x;
    logic signed [FIELD_BITS-1:0] pos_y;
    logic [FIELD_BITS-1:0]        heading;
    logic [FIELD_BITS-1:0]        weight;
    logic [FRAC_BITS-1:0]         offset_fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] out_x;
    logic signed [FIELD_BITS-1:0] out_y;
    logic [FIELD_BITS-1:0]        out_heading;
    logic [SLOT_BITS-1:0]         source_index;
    logic [SLOT_BITS-1:0]         best_index;
    logic                         last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // write one particle
    logic start;      // latch run parameters, kick the divider
    logic sum_step;   // read one weight for the total
    logic walk_init;  // rewind source and output indexes
    logic mult;       // first target and first running sum
    logic advance;    // step source index
    logic fetch;      // add fetched weight to running sum
    logic emit;       // produce one output beat
    logic sweep;      // write one equalized weight
    logic swap;       // flip the active pose bank
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_last;
    logic more;
    logic out_free;
    logic m_last;
    logic div_done;
  } status_t;

  // Register value to particles in use: zero acts as one, big values saturate
  function automatic logic [CNT_BITS-1:0] clamp_count(input logic [CFG_BITS-1:0] v);
    logic [CNT_BITS-1:0] r;
    if (v == '0) begin
      r = CNT_BITS'(1);
    end else if (v > CFG_MAX) begin
      r = CNT_BITS'(MAX_PARTICLES);
    end else begin
      r = v[CNT_BITS-1:0];
    end
    return r;
  endfunction

  // Coordinate field to stored width
  function automatic logic [COORD_BITS-1:0] coord_in(input logic [FIELD_BITS-1:0] v);
    logic [COORD_BITS+FIELD_BITS-1:0] w;
    w = {{COORD_BITS{1'b0}}, v};
    return w[COORD_BITS-1:0];
  endfunction

  // Stored coordinate sign-extended back to the field width
  function automatic logic [FIELD_BITS-1:0] coord_out(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS+FIELD_BITS-1:0] w;
    w = {{FIELD_BITS{v[COORD_BITS-1]}}, v};
    return w[FIELD_BITS-1:0];
  endfunction

  // Weight field to stored width
  function automatic logic [WEIGHT_BITS-1:0] weight_in(input logic [FIELD_BITS-1:0] v);
    logic [WEIGHT_BITS+FIELD_BITS-1:0] w;
    w = {{WEIGHT_BITS{1'b0}}, v};
    return w[WEIGHT_BITS-1:0];
  endfunction

endpackage

// ===== src/psr_divider.sv =====
// Restoring divider: all-ones weight over particle count, one bit per cycle.
`timescale 1ns / 1ps

module psr_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [psr_pkg::CNT_BITS-1:0]        divisor,
  output logic [psr_pkg::WEIGHT_BITS-1:0]     quotient,
  output logic                                done
);

  logic                                busy;
  logic [psr_pkg::DIV_STEP_BITS-1:0]   steps;
  logic [psr_pkg::CNT_BITS-1:0]        dvs;
  logic [psr_pkg::CNT_BITS-1:0]        rem;
  logic [psr_pkg::CNT_BITS:0]          rem_sh;
  logic                                fits;

  // Dividend bits are all ones, so a one shifts in every step
  assign rem_sh = {rem, 1'b1};
  assign fits   = rem_sh >= {1'b0, dvs};
  assign done   = !busy;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= psr_pkg::DIV_STEP_BITS'(psr_pkg::WEIGHT_BITS);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == psr_pkg::DIV_STEP_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem      <= psr_pkg::CNT_BITS'(rem_sh - {1'b0, dvs});
        quotient <= {quotient[psr_pkg::WEIGHT_BITS-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[psr_pkg::CNT_BITS-1:0];
        quotient <= {quotient[psr_pkg::WEIGHT_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/psr_datapath.sv =====
// Resampler datapath: particle stores, weight sums, target compare, output register.
`timescale 1ns / 1ps

module psr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  psr_pkg::cmd_t                         cmd,
  output psr_pkg::status_t                      status,
  input  logic                                  cfg_we,
  input  logic [psr_pkg::CFG_BITS-1:0]          cfg_value,
  input  psr_pkg::in_item_t                     in_item,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output psr_pkg::out_item_t                    out_item
);

  localparam int IB = psr_pkg::IDX_BITS;
  localparam int CB = psr_pkg::CNT_BITS;
  localparam int WB = psr_pkg::WEIGHT_BITS;

  // Stores
  psr_pkg::pose_t  pose_mem [2*psr_pkg::MAX_PARTICLES];
  logic [WB-1:0]   weight_mem [psr_pkg::MAX_PARTICLES];

  logic [psr_pkg::CFG_BITS-1:0] count_cfg;
  logic [CB-1:0]                cnt;
  logic [psr_pkg::FRAC_BITS-1:0] frac;
  logic [IB-1:0]                idx;
  logic                         bank;
  logic                         sum_acc;
  logic [psr_pkg::SUM_BITS-1:0] sum;
  logic [psr_pkg::LHS_BITS-1:0] lhs;
  logic [psr_pkg::TGT_BITS-1:0] target;
  logic [IB-1:0]                src;
  logic [IB-1:0]                m;
  logic [WB-1:0]                best_w;
  logic [IB-1:0]                best;
  logic [WB-1:0]                rd_w;
  psr_pkg::pose_t               rd_pose;

  logic [IB-1:0]                 rd_addr;
  logic [IB-1:0]                 slot_idx;
  logic                          slot_ok;
  logic [psr_pkg::WPROD_BITS-1:0] wprod;
  logic [psr_pkg::TGT_BITS-1:0]  tgt_init;
  logic [psr_pkg::CMP_BITS-1:0]  lhs_sh;
  logic                          take_best;
  logic [IB-1:0]                 best_new;
  logic [WB-1:0]                 quot;
  logic                          div_done;

  psr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .divisor  (psr_pkg::clamp_count(count_cfg)),
    .quotient (quot),
    .done     (div_done)
  );

  // Address and arithmetic
  assign slot_ok  = {1'b0, in_item.slot} < psr_pkg::SLOT_LIMIT;
  assign slot_idx = in_item.slot[IB-1:0];
  assign wprod    = {{CB{1'b0}}, rd_w} * {{WB{1'b0}}, cnt};
  assign tgt_init = psr_pkg::TGT_BITS'(frac) * psr_pkg::TGT_BITS'(sum);
  assign lhs_sh   = {lhs, {psr_pkg::FRAC_BITS{1'b0}}};
  assign take_best = (m == '0) || (rd_w > best_w);
  assign best_new  = take_best ? m : best;

  always_comb begin
    if (cmd.sum_step) begin
      rd_addr = idx;
    end else if (cmd.walk_init) begin
      rd_addr = '0;
    end else if (cmd.advance) begin
      rd_addr = src + 1'b1;
    end else begin
      rd_addr = src;
    end
  end

  // Status to the controller
  always_comb begin
    status.idx_last = (CB'(idx) == cnt - CB'(1));
    status.m_last   = (CB'(m) == cnt - CB'(1));
    status.more     = (CB'(src) + CB'(1) < cnt) &&
                      (lhs_sh < psr_pkg::CMP_BITS'(target));
    status.out_free = !out_valid || out_ready;
    status.div_done = div_done;
  end

  // Weight store
  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      weight_mem[slot_idx] <= psr_pkg::weight_in(in_item.weight);
    end else if (cmd.sweep) begin
      weight_mem[idx] <= quot;
    end
    rd_w <= weight_mem[rd_addr];
  end

  // Pose store, two banks
  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      pose_mem[{bank, slot_idx}] <= '{x:       psr_pkg::coord_in(in_item.pos_x),
                                      y:       psr_pkg::coord_in(in_item.pos_y),
                                      heading: in_item.heading};
    end else if (cmd.emit) begin
      pose_mem[{~bank, m}] <= rd_pose;
    end
    rd_pose <= pose_mem[{bank, rd_addr}];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg <= psr_pkg::CFG_RESET;
      bank      <= 1'b0;
      sum_acc   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_cfg <= cfg_value;
      end
      if (cmd.swap) begin
        bank <= ~bank;
      end
      sum_acc <= cmd.sum_step;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Run parameters and index counters
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt  <= psr_pkg::clamp_count(count_cfg);
      frac <= in_item.offset_fraction;
    end
    if (cmd.start || cmd.walk_init) begin
      idx <= '0;
    end else if (cmd.sum_step || cmd.sweep) begin
      idx <= idx + 1'b1;
    end
    if (cmd.walk_init) begin
      src <= '0;
      m   <= '0;
    end else begin
      if (cmd.advance) begin
        src <= src + 1'b1;
      end
      if (cmd.emit) begin
        m <= m + 1'b1;
      end
    end
  end

  // Total weight, running sum and target
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum <= '0;
    end else if (sum_acc) begin
      sum <= sum + psr_pkg::SUM_BITS'(rd_w);
    end
    if (cmd.mult) begin
      target <= tgt_init;
      lhs    <= psr_pkg::LHS_BITS'(wprod);
    end else begin
      if (cmd.fetch) begin
        lhs <= lhs + psr_pkg::LHS_BITS'(wprod);
      end
      if (cmd.emit) begin
        target <= target + psr_pkg::TGT_BITS'({sum, {psr_pkg::FRAC_BITS{1'b0}}});
      end
    end
  end

  // Best tracker and output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      best_w <= take_best ? rd_w : best_w;
      best   <= best_new;
      out_item.out_x        <= psr_pkg::coord_out(rd_pose.x);
      out_item.out_y        <= psr_pkg::coord_out(rd_pose.y);
      out_item.out_heading  <= rd_pose.heading;
      out_item.source_index <= psr_pkg::SLOT_BITS'(src);
      out_item.best_index   <= psr_pkg::SLOT_BITS'(best_new);
      out_item.last         <= status.m_last;
    end
  end

endmodule

// ===== src/psr_controller.sv =====
// Resampler sequencer: sum pass, systematic walk, weight rewrite.
`timescale 1ns / 1ps

module psr_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output psr_pkg::cmd_t     cmd,
  input  psr_pkg::status_t  status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SUM_END,
    ST_MULT,
    ST_CHECK,
    ST_FETCH,
    ST_SWEEP
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.load  = accept && (in_op == psr_pkg::OP_LOAD);
        cmd.start = accept && (in_op == psr_pkg::OP_RESAMPLE);
        if (cmd.start) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.idx_last) begin
          state_next = ST_SUM_END;
        end
      end
      ST_SUM_END: begin
        cmd.walk_init = 1'b1;
        state_next    = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.more) begin
          cmd.advance = 1'b1;
          state_next  = ST_FETCH;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.m_last) begin
            state_next = ST_SWEEP;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_SWEEP: begin
        if (status.div_done) begin
          cmd.sweep = 1'b1;
          if (status.idx_last) begin
            cmd.swap   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/particle_systematic_resampler_unit.sv =====
// Top level of the systematic particle resampler.
//
//  channel | dir | beat moves
//  --------+-----+--------------------------------------------------------
//  s_axis  | in  | load of one particle, or a resample request (tuser)
//  m_axis  | out | one resampled particle per beat, tlast on the final one
//  cfg     | in  | particle_count register write
//
// A resample of n particles runs through the accept, a pass that totals the
// weights one at a time through the single read port of the weight store,
// the first target, the walk over the outputs with at most n-1 source steps,
// and the rewrite of all n weights, which also waits for the 16-step divider.
// No input beat is taken meanwhile. Reset (rst, synchronous) sets
// particle_count to 64 and bank 0, stores not cleared; a stalled m_axis
// holds the walk at the next output.
`timescale 1ns / 1ps

module particle_systematic_resampler_unit (
  input  logic        clk,
  input  logic        rst,
  // tdata: slot[5:0], pos_x[21:6], pos_y[37:22], heading[53:38],
  //        weight[69:54], offset_fraction[85:70]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  // tuser: operation[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_x[15:0], out_y[31:16], out_heading[47:32],
  //        source_index[53:48], best_index[59:54]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  psr_pkg::cmd_t      cmd;
  psr_pkg::status_t   status;
  psr_pkg::in_item_t  in_item;
  psr_pkg::out_item_t out_item;

  // Input beat unpacking
  always_comb begin
    in_item.slot            = s_axis_tdata[5:0];
    in_item.pos_x           = s_axis_tdata[21:6];
    in_item.pos_y           = s_axis_tdata[37:22];
    in_item.heading         = s_axis_tdata[53:38];
    in_item.weight          = s_axis_tdata[69:54];
    in_item.offset_fraction = s_axis_tdata[85:70];
  end

  assign cfg_ready = 1'b1;

  psr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  psr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .in_item   (in_item),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_item  (out_item)
  );

  // Output beat packing
  assign m_axis_tdata = {4'b0000, out_item.best_index, out_item.source_index,
                         out_item.out_heading, out_item.out_y, out_item.out_x};
  assign m_axis_tlast = out_item.last;

`ifndef SYNTHESIS
  // An output is produced only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("output produced while result register is occupied");

  // After the bank swap the block takes input again
  a_swap_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.swap |=> s_axis_tready)
    else $error("not ready after bank swap");

  // No sum, walk or rewrite activity while input is being taken
  a_quiet_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !(cmd.sum_step || cmd.advance || cmd.fetch || cmd.sweep))
    else $error("resample activity while accepting input");
`endif

endmodule
